[rtl/stra_pkg.sv]
// ----------------------------------------------------------------------------
// Sparse table range argmax package
// Shared sizes, controller state type, action codes and table addressing.
// ----------------------------------------------------------------------------
`default_nettype none

package stra_pkg;

  // Store sizes.
  localparam int unsigned MAX_ITEMS = 1024;
  localparam int unsigned LEVELS    = 11;

  // Field widths.
  localparam int unsigned ACT_W = 2;
  localparam int unsigned VAL_W = 64;
  localparam int unsigned POS_W = 11;

  // Derived widths.
  localparam int unsigned IDX_W     = $clog2(MAX_ITEMS);
  localparam int unsigned LVL_W     = $clog2(LEVELS + 1);
  localparam int unsigned TAB_DEPTH = LEVELS * MAX_ITEMS;
  localparam int unsigned TAB_AW    = $clog2(TAB_DEPTH);
  localparam int unsigned SPAN_W    = LEVELS + 1;
  localparam int unsigned CMP_W     = SPAN_W + POS_W;
  localparam int unsigned T_W       = $clog2(POS_W);

  // Action codes of an input transaction.
  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_QCHK,
    ST_QTAB,
    ST_QVAL
  } state_e;

  // Flat table address of one level entry: level rows of MAX_ITEMS entries.
  function automatic logic [TAB_AW-1:0] tab_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [IDX_W-1:0] idx);
    tab_addr = TAB_AW'(lvl) * TAB_AW'(MAX_ITEMS) + TAB_AW'(idx);
  endfunction

endpackage

`default_nettype wire

[rtl/sparse_table_range_argmax.sv]
// ----------------------------------------------------------------------------
// Sparse table range argmax
// Appends signed values and answers range-maximum position queries from a
// sparse table of power-of-two spans kept in block memory.
//
//   Channel  Direction  Handshake         Payload
//   input    in         start / busy      action_i, value_i, left_i, right_i
//   result   out        valid_o (strobe)  position_o, bad_range_o
//
// A clear transaction does not raise busy. A load at new position p issues
// min(LEVELS-1, floor(log2(p))) table levels, one per cycle; each level reads
// the table and then the value memory before its merged position is written.
// A query passes through the check, table-read and value-read states (only the
// check state for a bad range); its result strobe comes in the cycle busy falls.
// Reset clears state, loaded count, level and valid flags but not the memories.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_table_range_argmax (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [stra_pkg::ACT_W-1:0] action_i,
  input  wire logic signed [stra_pkg::VAL_W-1:0] value_i,
  input  wire logic [stra_pkg::POS_W-1:0] left_i,
  input  wire logic [stra_pkg::POS_W-1:0] right_i,
  output logic                            valid_o,
  output logic      [stra_pkg::POS_W-1:0] position_o,
  output logic                            bad_range_o
);

  import stra_pkg::*;

  state_e state_q, state_d;

  // Control registers.
  logic [POS_W-1:0] count_q;
  logic [LVL_W-1:0] lvl_q;
  logic             s1_vld_q, s2_vld_q;
  logic             res_vld_q;

  // Payload registers.
  logic [POS_W-1:0]        p_q;
  logic [POS_W-1:0]        win_pos_q;
  logic signed [VAL_W-1:0] win_val_q;
  logic [LVL_W-1:0]        s1_lvl_q, s2_lvl_q;
  logic [IDX_W-1:0]        s1_idx_q, s2_idx_q;
  logic [POS_W-1:0]        s2_pos_q;
  logic [POS_W-1:0]        q_left_q, q_right_q, q_len_q;
  logic                    q_bad_q;
  logic [POS_W-1:0]        qa_q, qb_q;
  logic [POS_W-1:0]        res_pos_q;
  logic                    res_bad_q;

  // Memory ports.
  logic              tab_we;
  logic [TAB_AW-1:0] tab_waddr, tab_ra_addr, tab_rb_addr;
  logic [POS_W-1:0]  tab_wdata, tab_rd_a, tab_rd_b;
  logic              val_we;
  logic [IDX_W-1:0]  val_waddr, val_ra_addr, val_rb_addr;
  logic [VAL_W-1:0]  val_wdata, val_rd_a, val_rd_b;

  // Datapath signals.
  logic                    accept;
  logic                    full;
  logic [SPAN_W-1:0]       span;
  logic [IDX_W-1:0]        load_idx;
  logic                    load_issue;
  logic                    load_pick_left;
  logic [POS_W-1:0]        load_win_pos;
  logic signed [VAL_W-1:0] load_win_val;
  logic [T_W-1:0]          q_t;
  logic [POS_W-1:0]        q_span;
  logic                    q_too_long;
  logic                    q_reject;
  logic                    q_pick_left;
  logic [POS_W-1:0]        new_pos;

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign full    = (count_q == POS_W'(MAX_ITEMS));
  assign new_pos = count_q + POS_W'(1);

  // Load level issue: the entry of level lvl_q whose span ends at p_q.
  assign span       = SPAN_W'(1) << lvl_q;
  assign load_idx   = IDX_W'(CMP_W'(p_q) - CMP_W'(span));
  assign load_issue = (state_q == ST_LOAD) && (32'(lvl_q) < LEVELS) &&
                      (CMP_W'(span) <= CMP_W'(p_q));

  // Level merge: the left half wins only when strictly greater.
  assign load_pick_left = $signed(val_rd_a) > win_val_q;
  assign load_win_pos   = load_pick_left ? s2_pos_q : win_pos_q;
  assign load_win_val   = load_pick_left ? $signed(val_rd_a) : win_val_q;

  // Query level: floor of log2 of the range length.
  always_comb begin
    q_t = '0;
    for (int i = 0; i < POS_W; i++) begin
      if (q_len_q[i]) begin
        q_t = T_W'(i);
      end
    end
  end

  assign q_span      = POS_W'(1) << q_t;
  assign q_too_long  = (32'(q_t) >= LEVELS);
  assign q_reject    = q_bad_q || q_too_long;
  assign q_pick_left = $signed(val_rd_a) > $signed(val_rd_b);

  // Next state and memory controls.
  always_comb begin
    state_d     = state_q;
    tab_we      = 1'b0;
    tab_waddr   = tab_addr(s2_lvl_q, s2_idx_q);
    tab_wdata   = load_win_pos;
    val_we      = 1'b0;
    val_waddr   = IDX_W'(count_q);
    val_wdata   = value_i;
    tab_ra_addr = load_issue ? tab_addr(LVL_W'(lvl_q - LVL_W'(1)), load_idx)
                             : tab_addr(LVL_W'(q_t), IDX_W'(q_left_q - POS_W'(1)));
    tab_rb_addr = tab_addr(LVL_W'(q_t), IDX_W'(q_right_q - q_span));
    val_ra_addr = IDX_W'(tab_rd_a - POS_W'(1));
    val_rb_addr = IDX_W'(tab_rd_b - POS_W'(1));

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (action_i)
            ACT_LOAD: begin
              if (!full) begin
                val_we    = 1'b1;
                tab_we    = 1'b1;
                tab_waddr = tab_addr('0, IDX_W'(count_q));
                tab_wdata = new_pos;
                state_d   = ST_LOAD;
              end
            end
            ACT_QUERY: state_d = ST_QCHK;
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        tab_we = s2_vld_q;
        if (!load_issue && !s1_vld_q && !s2_vld_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_QCHK: state_d = q_reject ? ST_IDLE : ST_QTAB;
      ST_QTAB: state_d = ST_QVAL;
      ST_QVAL: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      lvl_q     <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      s1_vld_q  <= load_issue;
      s2_vld_q  <= s1_vld_q;
      res_vld_q <= ((state_q == ST_QCHK) && q_reject) || (state_q == ST_QVAL);
      if (accept && (action_i == ACT_CLEAR)) begin
        count_q <= '0;
      end else if (accept && (action_i == ACT_LOAD) && !full) begin
        count_q <= new_pos;
        lvl_q   <= LVL_W'(1);
      end else if (load_issue) begin
        lvl_q <= lvl_q + LVL_W'(1);
      end
    end
  end

  // Load pipeline and query payload.
  always_ff @(posedge clk_i) begin
    if (accept && (action_i == ACT_LOAD)) begin
      p_q       <= new_pos;
      win_pos_q <= new_pos;
      win_val_q <= value_i;
    end else if (s2_vld_q) begin
      win_pos_q <= load_win_pos;
      win_val_q <= load_win_val;
    end
    if (accept && (action_i == ACT_QUERY)) begin
      q_left_q  <= left_i;
      q_right_q <= right_i;
      q_len_q   <= right_i - left_i + POS_W'(1);
      q_bad_q   <= (left_i == '0) || (left_i > right_i) || (right_i > count_q);
    end
    if (load_issue) begin
      s1_lvl_q <= lvl_q;
      s1_idx_q <= load_idx;
    end
    if (s1_vld_q) begin
      s2_lvl_q <= s1_lvl_q;
      s2_idx_q <= s1_idx_q;
      s2_pos_q <= tab_rd_a;
    end
    if (state_q == ST_QTAB) begin
      qa_q <= tab_rd_a;
      qb_q <= tab_rd_b;
    end
    if ((state_q == ST_QCHK) && q_reject) begin
      res_pos_q <= '0;
      res_bad_q <= 1'b1;
    end else if (state_q == ST_QVAL) begin
      res_pos_q <= q_pick_left ? qa_q : qb_q;
      res_bad_q <= 1'b0;
    end
  end

  // Sparse table: one row of positions per level.
  stra_ram #(
    .WIDTH (POS_W),
    .DEPTH (TAB_DEPTH)
  ) u_tab_ram (
    .clk_i     (clk_i),
    .we_i      (tab_we),
    .waddr_i   (tab_waddr),
    .wdata_i   (tab_wdata),
    .raddr_a_i (tab_ra_addr),
    .rdata_a_o (tab_rd_a),
    .raddr_b_i (tab_rb_addr),
    .rdata_b_o (tab_rd_b)
  );

  // Loaded values by position.
  stra_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ITEMS)
  ) u_val_ram (
    .clk_i     (clk_i),
    .we_i      (val_we),
    .waddr_i   (val_waddr),
    .wdata_i   (val_wdata),
    .raddr_a_i (val_ra_addr),
    .rdata_a_o (val_rd_a),
    .raddr_b_i (val_rb_addr),
    .rdata_b_o (val_rd_b)
  );

  // Result transaction.
  assign valid_o     = res_vld_q;
  assign position_o  = res_pos_q;
  assign bad_range_o = res_bad_q;

endmodule

`default_nettype wire

[rtl/stra_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module stra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire
